/* src/bpar_pkg.sv */
// ----------------------------------------------------------------------------
// BLE private address resolver package
// AES-128 helper functions and shared constants.
// ----------------------------------------------------------------------------
package bpar_pkg;

	localparam int Rounds = 10;

	typedef enum logic [0:0] {
		REG_KEY_LOW  = 1'b0,
		REG_KEY_HIGH = 1'b1
	} reg_idx_t;

	localparam logic [1:0] TypeResolvable = 2'b01;

	typedef logic [7:0] sbox_tbl_t [256];

	localparam sbox_tbl_t Sbox = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	typedef logic [7:0] rcon_tbl_t [Rounds];
	localparam rcon_tbl_t Rcon = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	// Multiply by x in GF(2^8)
	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// One AES round, without MixColumns when last is set; byte i of the state sits in bits 8i+7:8i
	function automatic logic [127:0] aes_round(input logic [127:0] s,
		input logic [127:0] rk, input logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [127:0] o;
		logic [7:0] a0, a1, a2, a3;
		for (int i = 0; i < 16; i++) b[i] = Sbox[s[8*i +: 8]];
		for (int c = 0; c < 4; c++)
			for (int j = 0; j < 4; j++)
				t[j + 4*c] = b[j + 4*((c + j) % 4)];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			if (last) begin
				o[32*c +: 32] = {a3, a2, a1, a0};
			end else begin
				o[32*c      +: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
				o[32*c + 8  +: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
				o[32*c + 16 +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
				o[32*c + 24 +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
			end
		end
		aes_round = o ^ rk;
	endfunction

	// Next round key from the previous one
	function automatic logic [127:0] key_next(input logic [127:0] k,
		input logic [7:0] rc);
		logic [31:0] t;
		logic [127:0] o;
		t = {Sbox[k[103:96]], Sbox[k[127:120]], Sbox[k[119:112]],
			Sbox[k[111:104]] ^ rc};
		o[31:0]   = k[31:0] ^ t;
		o[63:32]  = k[63:32] ^ o[31:0];
		o[95:64]  = k[95:64] ^ o[63:32];
		o[127:96] = k[127:96] ^ o[95:64];
		key_next = o;
	endfunction

endpackage

/* src/ble_private_address_resolver.sv */
// ----------------------------------------------------------------------------
// BLE private address resolver
// Resolves or generates resolvable private addresses with the AES-128 ah hash.
// ----------------------------------------------------------------------------
// Usage:
//  Input words arrive on s_axis (tdata: func, address, random_part), results
//  leave on m_axis (tdata: address_type, resolved, hash_value, address_out).
//  The identity key is written through cfg (index 0 low half, 1 high half);
//  the user must write it only while the block is idle; the block does not
//  enforce this. The round keys are expanded into registers one round per
//  cycle, a wave that runs alongside the first word after a key write, so a
//  word may follow the write at once. The pipeline has one input stage, ten
//  AES round stages and one result stage and is limited by one AES round
//  (S-box, MixColumns, key add) per stage. Throughput is one word per cycle,
//  but when the receiver stalls, the whole pipeline holds; s_axis_tready
//  drops only while the last stage holds a word that is not taken.
//  Reset clears the key, the valid bits and the output valid.
// ----------------------------------------------------------------------------
module ble_private_address_resolver (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: func[0], address[48:1], random_part[70:49], zero fill
	input  logic [71:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: address_type[1:0], resolved[2], hash_value[26:3],
	// address_out[74:27], zero fill
	output logic [79:0]  m_axis_tdata
);
	import bpar_pkg::*;

	localparam int Stages = Rounds + 1;

	logic [127:0] key_q;
	logic [127:0] rk_q [Rounds];
	logic         adv;
	logic         vld_s [Stages];
	logic [127:0] st_s  [Stages];
	logic [47:0]  adr_s [Stages];
	logic         gen_s [Stages];
	logic         out_vld_q;
	logic [79:0]  out_data_q;

	assign cfg_ready = 1'b1;
	assign adv = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KEY_LOW:  key_q[63:0]   <= cfg_data;
				REG_KEY_HIGH: key_q[127:64] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Expand round keys, one round per register
	always_ff @(posedge clk) begin
		rk_q[0] <= key_next(key_q, Rcon[0]);
		for (int r = 1; r < Rounds; r++) rk_q[r] <= key_next(rk_q[r-1], Rcon[r]);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Stages; i++) vld_s[i] <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= s_axis_tvalid;
			for (int i = 1; i < Stages; i++) vld_s[i] <= vld_s[i-1];
			out_vld_q <= vld_s[Stages-1];
		end
	end

	// Input stage: form the address and the initial AES state
	logic        in_gen;
	logic [47:0] in_adr;
	assign in_gen = s_axis_tdata[0];
	assign in_adr = in_gen ? {TypeResolvable, s_axis_tdata[70:49], 24'h000000}
		: s_axis_tdata[48:1];

	// Advance the pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0]  <= {104'h0, in_adr[47:24]} ^ key_q;
			adr_s[0] <= in_adr;
			gen_s[0] <= in_gen;
			for (int i = 1; i < Stages; i++) begin
				st_s[i]  <= aes_round(st_s[i-1], rk_q[i-1], i == Rounds);
				adr_s[i] <= adr_s[i-1];
				gen_s[i] <= gen_s[i-1];
			end
		end
	end

	// Result stage
	logic [23:0] hash;
	logic [47:0] adr_fin;
	logic        match;
	assign hash    = st_s[Stages-1][23:0];
	assign adr_fin = gen_s[Stages-1] ? {adr_s[Stages-1][47:24], hash} : adr_s[Stages-1];
	assign match   = (adr_fin[47:46] == TypeResolvable) && (adr_fin[23:0] == hash);

	always_ff @(posedge clk) begin
		if (adv) out_data_q <= {5'h00, adr_fin, hash, match, adr_fin[47:46]};
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* src/bpar_checker.sv */
// ----------------------------------------------------------------------------
// BLE private address resolver checker
// Port-level properties of the resolver, bound to the top level.
// ----------------------------------------------------------------------------
module bpar_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata
);
	// Hold a stalled output word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// Resolved implies resolvable type
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == 2'b01)
		else $error("resolved without resolvable type");

	// Resolved implies hash equals address bytes 0..2
	a_hash: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[26:3] == m_axis_tdata[50:27])
		else $error("resolved with hash mismatch");

	// Accept input whenever output is free
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");
endmodule

bind ble_private_address_resolver bpar_checker u_bpar_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BLE private address resolver testbench
// Drives resolve and generate words under several identity keys, with random
// gaps on both sides, and checks every result against an AES-128 ah predictor.
// ----------------------------------------------------------------------------
module testbench;

	import bpar_pkg::*;

	localparam int  LimitCycles = 400000;
	localparam int  RandomItems = 450;
	localparam bit  FuncResolve = 1'b0;
	localparam bit  FuncGenerate = 1'b1;

	// Packed with address_type in the lowest bits, as on m_axis_tdata
	typedef struct packed {
		logic [47:0] addr_out;
		logic [23:0] hash;
		logic        resolved;
		logic [1:0]  addr_type;
	} result_t;

	// Directed row: expected result given only where it can be read off directly
	typedef struct {
		logic        func;
		logic [47:0] addr;
		logic [21:0] rnd;
		logic        has_exp;
		result_t     exp;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [0:0]   cfg_index = '0;
	logic [63:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [71:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [79:0]  m_axis_tdata;

	logic [63:0]  key_low = '0;
	logic [63:0]  key_high = '0;
	result_t      pending_results [$];
	int           errors = 0;
	int           checked = 0;
	int           cycles = 0;
	int           match_count = 0;
	int           stall_left = 0;

	ble_private_address_resolver u_top (.*);

	always #5 clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LimitCycles) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------- AES-128 predictor ----------------

	function automatic logic [7:0] gf_x2(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = gf_x2(a);
		end
		return p;
	endfunction

	// S-box computed from the field inverse and affine map, not from a table
	function automatic logic [7:0] sub_byte(input logic [7:0] x);
		logic [7:0] r, b, y;
		r = 8'h01;
		b = x;
		for (int e = 0; e < 8; e++) begin
			if (8'd254 >> e & 1) r = gf_mul(r, b);
			b = gf_mul(b, b);
		end
		if (x == 0) r = 0;
		y = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]};
		return y ^ 8'h63;
	endfunction

	function automatic logic [23:0] ah_hash(input logic [23:0] prand);
		logic [7:0] w [176];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] k [4];
		logic [7:0] f, rc, a0, a1, a2, a3;
		rc = 8'h01;
		for (int i = 0; i < 8; i++) begin
			w[i] = key_low[8*i +: 8];
			w[8+i] = key_high[8*i +: 8];
		end
		for (int i = 16; i < 176; i += 4) begin
			for (int j = 0; j < 4; j++) k[j] = w[i-4+j];
			if (i % 16 == 0) begin
				f = k[0];
				k[0] = sub_byte(k[1]) ^ rc;
				k[1] = sub_byte(k[2]);
				k[2] = sub_byte(k[3]);
				k[3] = sub_byte(f);
				rc = gf_x2(rc);
			end
			for (int j = 0; j < 4; j++) w[i+j] = w[i-16+j] ^ k[j];
		end
		for (int i = 0; i < 16; i++) s[i] = (i < 3 ? prand[8*i +: 8] : 8'h00) ^ w[i];
		for (int r = 1; r <= 10; r++) begin
			for (int i = 0; i < 16; i++) s[i] = sub_byte(s[i]);
			for (int c = 0; c < 4; c++)
				for (int j = 0; j < 4; j++)
					t[j+4*c] = s[j + 4*((c+j)%4)];
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				if (r < 10) begin
					s[4*c]   = gf_x2(a0) ^ gf_x2(a1) ^ a1 ^ a2 ^ a3;
					s[4*c+1] = a0 ^ gf_x2(a1) ^ gf_x2(a2) ^ a2 ^ a3;
					s[4*c+2] = a0 ^ a1 ^ gf_x2(a2) ^ gf_x2(a3) ^ a3;
					s[4*c+3] = gf_x2(a0) ^ a0 ^ a1 ^ a2 ^ gf_x2(a3);
				end else begin
					s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
				end
			end
			for (int i = 0; i < 16; i++) s[i] ^= w[16*r+i];
		end
		return {s[2], s[1], s[0]};
	endfunction

	function automatic result_t resolve_word(input logic func, input logic [47:0] addr,
		input logic [21:0] rnd);
		result_t res;
		logic [23:0] prand;
		if (func == FuncGenerate) begin
			prand = {TypeResolvable, rnd};
			res.hash = ah_hash(prand);
			res.addr_out = {prand, res.hash};
		end else begin
			prand = addr[47:24];
			res.hash = ah_hash(prand);
			res.addr_out = addr;
		end
		res.addr_type = res.addr_out[47:46];
		res.resolved = (res.addr_type == TypeResolvable) && (res.addr_out[23:0] == res.hash);
		return res;
	endfunction

	// ---------------- driving ----------------

	// Drop valid and idle for a random number of cycles
	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 9);
		if (n < 5) n = 0;
		else if (n < 9) n = $urandom_range(1, 3);
		else n = $urandom_range(10, 40);
		if (n != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_word(input logic func, input logic [47:0] addr,
		input logic [21:0] rnd, input logic has_exp, input result_t exp);
		result_t res;
		res = resolve_word(func, addr, rnd);
		if (has_exp && res !== exp)
			$display("note: directed expectation differs from predictor");
		pending_results.push_back(has_exp ? exp : res);
		s_axis_tdata <= {1'b0, rnd, addr, func};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if ($urandom_range(0, 3) == 0) idle_gap();
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Write one key half, then idle
	task automatic write_key(input reg_idx_t idx, input logic [63:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_KEY_LOW) key_low = value;
		else key_high = value;
		repeat (12) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [47:0] got,
		input logic [47:0] want);
		errors++;
		$display("mismatch at result %0d: %s got %h want %h", checked, what, got, want);
	endtask

	// ---------------- result checking ----------------

	// Receiver ready: mostly short random gaps, now and then a long stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 99) == 0) begin
				stall_left <= $urandom_range(10, 40);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
			end
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[74:0];
			if (pending_results.size() == 0) begin
				errors++;
				$display("unexpected result word %h", m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				if (got.addr_type !== want.addr_type)
					report_mismatch("address_type", 48'(got.addr_type),
						48'(want.addr_type));
				if (got.resolved !== want.resolved)
					report_mismatch("resolved", 48'(got.resolved), 48'(want.resolved));
				if (got.hash !== want.hash)
					report_mismatch("hash_value", 48'(got.hash), 48'(want.hash));
				if (got.addr_out !== want.addr_out)
					report_mismatch("address_out", got.addr_out, want.addr_out);
				if (want.resolved) match_count++;
			end
			checked++;
		end
	end

	// ---------------- stimulus ----------------

	task automatic random_phase(input int count);
		logic [47:0] addr;
		logic [21:0] rnd;
		result_t gen;
		for (int i = 0; i < count; i++) begin
			rnd = 22'($urandom);
			addr = 48'({$urandom, $urandom});
			case ($urandom_range(0, 3))
				0: begin
					// Resolve a correctly generated address so matches occur, now and then with one bit flipped
					gen = resolve_word(FuncGenerate, '0, rnd);
					addr = gen.addr_out;
					if ($urandom_range(0, 4) == 0) addr[$urandom_range(0, 47)] ^= 1'b1;
					send_word(FuncResolve, addr, 22'($urandom), 1'b0, gen);
				end
				1: send_word(FuncGenerate, addr, rnd, 1'b0, gen);
				default: send_word(FuncResolve, addr, rnd, 1'b0, gen);
			endcase
			idle_gap();
		end
	endtask

	initial begin
		row_t rows [$];
		row_t r;
		result_t none;
		none = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset key of zero
		r = '{FuncResolve, 48'h0, 22'h0, 1'b0, none};                  rows.push_back(r);
		r = '{FuncResolve, 48'hffff_ffff_ffff, 22'h3fffff, 1'b0, none}; rows.push_back(r);
		r = '{FuncResolve, 48'h4000_0000_0000, 22'h0, 1'b0, none};      rows.push_back(r);
		r = '{FuncResolve, 48'h8000_0000_0000, 22'h0, 1'b0, none};      rows.push_back(r);
		r = '{FuncResolve, 48'hc000_0000_0000, 22'h0, 1'b0, none};      rows.push_back(r);
		r = '{FuncResolve, 48'h3fff_ffff_ffff, 22'h0, 1'b0, none};      rows.push_back(r);
		r = '{FuncGenerate, 48'h0, 22'h0, 1'b0, none};                  rows.push_back(r);
		r = '{FuncGenerate, 48'hffff_ffff_ffff, 22'h3fffff, 1'b0, none}; rows.push_back(r);
		r = '{FuncGenerate, 48'h0, 22'h155555, 1'b0, none};             rows.push_back(r);
		r = '{FuncGenerate, 48'h0, 22'h2aaaaa, 1'b0, none};             rows.push_back(r);
		foreach (rows[i]) send_word(rows[i].func, rows[i].addr, rows[i].rnd,
			rows[i].has_exp, rows[i].exp);

		// Pause the sender until every result is back, then change keys
		drain();
		write_key(REG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
		write_key(REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
		random_phase(60);
		drain();
		write_key(REG_KEY_LOW, {$urandom, $urandom});
		write_key(REG_KEY_HIGH, {$urandom, $urandom});
		random_phase(RandomItems - 120);
		drain();
		write_key(REG_KEY_LOW, 64'h0);
		write_key(REG_KEY_HIGH, 64'h8000_0000_0000_0001);
		random_phase(60);
		drain();

		$display("checked %0d result words (%0d address matches) over four key settings",
			checked, match_count);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* ble_private_address_resolver.f */
src/bpar_pkg.sv
src/ble_private_address_resolver.sv
src/bpar_checker.sv
test/testbench.sv
